/* hw/rtl/uct_pkg.sv */
// Package for the URL component tokenizer: field widths, parse states,
// result kinds, status codes, result record and span helpers.
// No dependencies.
package uct_pkg;

  localparam int MAX_URL_BYTES = 4096;

  // position counts up to MAX_URL_BYTES inclusive; a delimiter is always below it
  localparam int POS_W  = $clog2(MAX_URL_BYTES + 1);
  localparam int DLM_W  = $clog2(MAX_URL_BYTES);
  localparam int SUM_W  = POS_W + 1;
  localparam int WIDE_W = 32;

  localparam int OFF_W  = 12;
  localparam int LEN_W  = 13;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int NKIND  = 6;

  localparam int HOST_SKIP = 3;  // ':' plus "//" ahead of the host

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_REPORT_ENABLE = 1'b0;
  localparam logic [NKIND-1:0] REPORT_ENABLE_RST = '1;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;

  typedef enum logic [0:0] {
    ACT_BYTE = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    PS_START    = 4'd0,
    PS_PROTOCOL = 4'd1,
    PS_SLASH1   = 4'd2,
    PS_SLASH2   = 4'd3,
    PS_HOST     = 4'd4,
    PS_PREPORT  = 4'd5,
    PS_PORT     = 4'd6,
    PS_SEGMENT  = 4'd7,
    PS_KEY      = 4'd8,
    PS_VALUE    = 4'd9,
    PS_ERROR    = 4'd10
  } parse_state_t;

  typedef enum logic [KIND_W-1:0] {
    TK_PROTOCOL = 3'd0,
    TK_HOST     = 3'd1,
    TK_PORT     = 3'd2,
    TK_SEGMENT  = 3'd3,
    TK_PAIR     = 3'd4,
    TK_COMPLETE = 3'd5
  } tok_kind_t;

  typedef enum logic [STAT_W-1:0] {
    STS_OK       = 2'd0,
    STS_BAD_END  = 2'd1,
    STS_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    tok_kind_t        kind;
    logic [OFF_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] key_off;
    logic [LEN_W-1:0] key_len;
    status_t          status;
  } result_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } queue_entry_t;

  function automatic logic [SUM_W-1:0] span(input logic [SUM_W-1:0] from_v,
                                            input logic [SUM_W-1:0] to_v);
    return (to_v > from_v) ? to_v - from_v : '0;
  endfunction

  function automatic logic [LEN_W-1:0] fit_len(input logic [SUM_W-1:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[LEN_W-1:0];
  endfunction

  function automatic logic [OFF_W-1:0] fit_off(input logic [SUM_W-1:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[OFF_W-1:0];
  endfunction

endpackage

/* hw/rtl/uct_if.sv */
// Valid/ready channel interfaces for the URL component tokenizer:
// one for URL bytes in, one for result records out. Uses uct_pkg.
interface uct_in_if;
  logic               valid;
  logic               ready;
  uct_pkg::action_t   action;
  logic [7:0]         ch;

  modport source (output valid, action, ch, input ready);
  modport sink   (input valid, action, ch, output ready);
endinterface

interface uct_out_if;
  logic                            valid;
  logic                            ready;
  uct_pkg::tok_kind_t              token_kind;
  logic [uct_pkg::OFF_W-1:0]       start_offset;
  logic [uct_pkg::LEN_W-1:0]       length;
  logic [uct_pkg::OFF_W-1:0]       key_offset;
  logic [uct_pkg::LEN_W-1:0]       key_length;
  uct_pkg::status_t                status;
  logic                            last;

  modport source (output valid, token_kind, start_offset, length, key_offset,
                  key_length, status, last, input ready);
  modport sink   (input valid, token_kind, start_offset, length, key_offset,
                  key_length, status, last, output ready);
endinterface

/* hw/rtl/url_component_tokenizer.sv */
// URL component tokenizer top level: parse state machine, result queue
// and APB-style report enable register. Uses uct_pkg and uct_if.
//
//   channel   direction  transfer contents
//   in_chan   in         action, ch (one URL byte or end of URL)
//   out_chan  out        token_kind, offsets, lengths, status, last
//   APB       in/out     report_enable at byte address 0
//
// One input item is taken per cycle while in_chan.ready is high; its results
// land in a 4-entry queue at the same edge. The queue drains one result per
// cycle while out_chan.ready is high; an end item that flushes a segment or pair
// can queue two results. in_chan.ready drops while more than two results are queued.
// rst_n is synchronous and clears the parse state, queue and register.
module url_component_tokenizer (
  input  logic                             clk,
  input  logic                             rst_n,
  uct_in_if.sink                           in_chan,
  uct_out_if.source                        out_chan,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [uct_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [uct_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [uct_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import uct_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration
  logic [NKIND-1:0] report_en_r;
  logic             cfg_wr;
  logic             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1];
  assign cfg_wr  = psel & penable & pwrite & pready & (cfg_idx == REG_REPORT_ENABLE);
  assign prdata  = (cfg_idx == REG_REPORT_ENABLE) ? CFG_DATA_W'(report_en_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_en_r <= REPORT_ENABLE_RST;
    end else if (cfg_wr) begin
      report_en_r <= pwdata[NKIND-1:0];
    end
  end

  // parse state
  parse_state_t     state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [DLM_W-1:0] dlm_r, dlm_nxt;
  logic [OFF_W-1:0] key_start_r, key_start_nxt;
  logic [LEN_W-1:0] key_len_r, key_len_nxt;
  logic             too_long_r, too_long_nxt;

  // result queue
  queue_entry_t      q_mem [QDEPTH];
  logic [QPTR_W-1:0] q_wp_r, q_rp_r;
  logic [QCNT_W-1:0] q_cnt_r;

  logic          accept, pop;
  logic          res_a_v;
  result_t       res_a, res_b;
  logic          push_a, push_b;
  queue_entry_t  ent0, ent1;
  logic [SUM_W-1:0] p_x, d1_x, d3_x, seg_len;
  status_t       end_status;

  assign in_chan.ready = (q_cnt_r <= QCNT_W'(QDEPTH - 2));
  assign accept        = in_chan.valid & in_chan.ready;

  always_comb begin
    p_x     = SUM_W'(pos_r);
    d1_x    = SUM_W'(dlm_r) + SUM_W'(1);
    d3_x    = SUM_W'(dlm_r) + SUM_W'(HOST_SKIP);
    seg_len = span(d1_x, p_x);

    state_nxt     = state_r;
    pos_nxt       = pos_r;
    dlm_nxt       = dlm_r;
    key_start_nxt = key_start_r;
    key_len_nxt   = key_len_r;
    too_long_nxt  = too_long_r;

    res_a_v = 1'b0;
    res_a   = '{kind: TK_SEGMENT, start: fit_off(d1_x), len: fit_len(seg_len),
                key_off: '0, key_len: '0, status: STS_OK};

    if (too_long_r) begin
      end_status = STS_TOO_LONG;
    end else if (state_r == PS_SEGMENT || state_r == PS_VALUE ||
                 state_r == PS_HOST || state_r == PS_PORT) begin
      end_status = STS_OK;
    end else begin
      end_status = STS_BAD_END;
    end
    res_b = '{kind: TK_COMPLETE, start: '0, len: fit_len(p_x),
              key_off: '0, key_len: '0, status: end_status};

    if (in_chan.action == ACT_END) begin
      if (state_r == PS_SEGMENT) begin
        res_a_v = 1'b1;
      end else if (state_r == PS_VALUE) begin
        res_a_v       = 1'b1;
        res_a.kind    = TK_PAIR;
        res_a.key_off = key_start_r;
        res_a.key_len = key_len_r;
      end
      state_nxt     = PS_START;
      pos_nxt       = '0;
      dlm_nxt       = '0;
      key_start_nxt = '0;
      key_len_nxt   = '0;
      too_long_nxt  = 1'b0;
    end else if (pos_r >= POS_W'(MAX_URL_BYTES)) begin
      // byte past the bound is dropped
      too_long_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      unique case (state_r)
        PS_START: begin
          state_nxt = (in_chan.ch == CH_SLASH) ? PS_SEGMENT : PS_PROTOCOL;
        end
        PS_PROTOCOL: begin
          if (in_chan.ch == CH_COLON) begin
            res_a_v     = 1'b1;
            res_a.kind  = TK_PROTOCOL;
            res_a.start = '0;
            res_a.len   = fit_len(p_x);
            dlm_nxt     = pos_r[DLM_W-1:0];
            state_nxt   = PS_SLASH1;
          end
        end
        PS_SLASH1: begin
          state_nxt = (in_chan.ch == CH_SLASH) ? PS_SLASH2 : PS_ERROR;
        end
        PS_SLASH2: begin
          state_nxt = (in_chan.ch == CH_SLASH) ? PS_HOST : PS_ERROR;
        end
        PS_HOST: begin
          if (in_chan.ch == CH_COLON) begin
            res_a_v     = 1'b1;
            res_a.kind  = TK_HOST;
            res_a.start = fit_off(d3_x);
            res_a.len   = fit_len(span(d3_x, p_x));
            dlm_nxt     = pos_r[DLM_W-1:0];
            state_nxt   = PS_PREPORT;
          end
        end
        PS_PREPORT: begin
          state_nxt = (in_chan.ch == CH_SLASH) ? PS_ERROR : PS_PORT;
        end
        PS_PORT: begin
          if (in_chan.ch == CH_SLASH) begin
            res_a_v    = 1'b1;
            res_a.kind = TK_PORT;
            dlm_nxt    = pos_r[DLM_W-1:0];
            state_nxt  = PS_SEGMENT;
          end
        end
        PS_SEGMENT: begin
          if (in_chan.ch == CH_SLASH || in_chan.ch == CH_QUEST) begin
            res_a_v = 1'b1;
            dlm_nxt = pos_r[DLM_W-1:0];
            if (in_chan.ch == CH_QUEST) begin
              state_nxt = PS_KEY;
            end
          end
        end
        PS_KEY: begin
          if (in_chan.ch == CH_EQUAL) begin
            key_start_nxt = fit_off(d1_x);
            key_len_nxt   = fit_len(seg_len);
            dlm_nxt       = pos_r[DLM_W-1:0];
            state_nxt     = PS_VALUE;
          end
        end
        PS_VALUE: begin
          if (in_chan.ch == CH_AMP) begin
            res_a_v       = 1'b1;
            res_a.kind    = TK_PAIR;
            res_a.key_off = key_start_r;
            res_a.key_len = key_len_r;
            dlm_nxt       = pos_r[DLM_W-1:0];
            state_nxt     = PS_KEY;
          end
        end
        default: begin
          state_nxt = PS_ERROR;
        end
      endcase
    end

    push_a = accept & res_a_v & report_en_r[res_a.kind];
    push_b = accept & (in_chan.action == ACT_END) & report_en_r[TK_COMPLETE];

    // first written slot carries the flush/byte result if there is one
    ent0 = push_a ? queue_entry_t'{res: res_a, last: ~push_b}
                  : queue_entry_t'{res: res_b, last: 1'b1};
    ent1 = queue_entry_t'{res: res_b, last: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PS_START;
      pos_r       <= '0;
      dlm_r       <= '0;
      key_start_r <= '0;
      key_len_r   <= '0;
      too_long_r  <= 1'b0;
    end else if (accept) begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      dlm_r       <= dlm_nxt;
      key_start_r <= key_start_nxt;
      key_len_r   <= key_len_nxt;
      too_long_r  <= too_long_nxt;
    end
  end

  // result queue
  assign pop = out_chan.valid & out_chan.ready;

  always_ff @(posedge clk) begin
    if (push_a | push_b) begin
      q_mem[q_wp_r] <= ent0;
    end
    if (push_a & push_b) begin
      q_mem[q_wp_r + QPTR_W'(1)] <= ent1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wp_r  <= q_wp_r + QPTR_W'(push_a) + QPTR_W'(push_b);
      q_rp_r  <= q_rp_r + QPTR_W'(pop);
      q_cnt_r <= q_cnt_r + QCNT_W'(push_a) + QCNT_W'(push_b) - QCNT_W'(pop);
    end
  end

  assign out_chan.valid        = (q_cnt_r != '0);
  assign out_chan.token_kind   = q_mem[q_rp_r].res.kind;
  assign out_chan.start_offset = q_mem[q_rp_r].res.start;
  assign out_chan.length       = q_mem[q_rp_r].res.len;
  assign out_chan.key_offset   = q_mem[q_rp_r].res.key_off;
  assign out_chan.key_length   = q_mem[q_rp_r].res.key_len;
  assign out_chan.status       = q_mem[q_rp_r].res.status;
  assign out_chan.last         = q_mem[q_rp_r].last;

endmodule
